// ----- rtl/core/mcsr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsr_pkg
// shared types, constants and reply byte tables for the ci responder core
// ----------------------------------------------------------------------------
package mcsr_pkg;

    localparam int unsigned CMDQ_DEPTH_DEFAULT = 2;

    localparam int unsigned ID_W   = 28;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned IDX_W  = 5;

    localparam logic [CNT_W-1:0] MSG_MIN_LEN = 5'd16;

    localparam logic [7:0] SYX_START     = 8'hF0;
    localparam logic [7:0] SYX_UNIVERSAL = 8'h7E;
    localparam logic [7:0] SYX_CI        = 8'h0D;
    localparam logic [7:0] SYX_VERSION   = 8'h02;
    localparam logic [7:0] SYX_EOX       = 8'hF7;

    localparam logic [7:0] SUB_DISCOVERY       = 8'h70;
    localparam logic [7:0] SUB_DISCOVERY_REPLY = 8'h71;
    localparam logic [7:0] SUB_PROFILE         = 8'h20;
    localparam logic [7:0] SUB_PROFILE_REPLY   = 8'h21;

    localparam logic [ID_W-1:0] BROADCAST_ID = 28'hFFFFFFF;

    // command kinds passed from front to back
    localparam logic [1:0] KIND_REJECT = 2'd0;
    localparam logic [1:0] KIND_DISC   = 2'd1;
    localparam logic [1:0] KIND_PROF   = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX_DISC = 5'd30;
    localparam logic [IDX_W-1:0] LAST_IDX_PROF = 5'd22;
    localparam logic [IDX_W-1:0] LAST_IDX_REJ  = 5'd0;

    // configuration register byte addresses
    localparam logic [1:0] ADDR_OWN_ID = 2'd0;

    typedef struct packed {
        logic [1:0]      kind;
        logic [6:0]      channel;
        logic [ID_W-1:0] sender;
    } cmd_t;

    localparam logic [7:0] DISC_BODY [16] = '{
        8'h7D, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
        8'h02, 8'h01, 8'h00, 8'h0E, 8'h00, 8'h02, 8'h00, 8'h00
    };

    localparam logic [7:0] PROF_ID [5] = '{8'h7D, 8'h47, 8'h49, 8'h4E, 8'h47};

    function automatic logic [IDX_W-1:0] last_idx_f(input logic [1:0] kind);
        logic [IDX_W-1:0] r;
        unique case (kind)
            KIND_DISC: r = LAST_IDX_DISC;
            KIND_PROF: r = LAST_IDX_PROF;
            default:   r = LAST_IDX_REJ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] reply_byte_f(
        input cmd_t            cmd,
        input logic [ID_W-1:0] own_id,
        input logic [IDX_W-1:0] idx
    );
        logic [7:0]       r;
        logic [IDX_W-1:0] body_idx;
        body_idx = idx - 5'd14;
        r = 8'h00;
        if (cmd.kind == KIND_REJECT) begin
            r = 8'h00;
        end else begin
            unique case (idx)
                5'd0:  r = SYX_START;
                5'd1:  r = SYX_UNIVERSAL;
                5'd2:  r = {1'b0, cmd.channel};
                5'd3:  r = SYX_CI;
                5'd4:  r = (cmd.kind == KIND_DISC) ? SUB_DISCOVERY_REPLY : SUB_PROFILE_REPLY;
                5'd5:  r = SYX_VERSION;
                5'd6:  r = {1'b0, own_id[6:0]};
                5'd7:  r = {1'b0, own_id[13:7]};
                5'd8:  r = {1'b0, own_id[20:14]};
                5'd9:  r = {1'b0, own_id[27:21]};
                5'd10: r = {1'b0, cmd.sender[6:0]};
                5'd11: r = {1'b0, cmd.sender[13:7]};
                5'd12: r = {1'b0, cmd.sender[20:14]};
                5'd13: r = {1'b0, cmd.sender[27:21]};
                default:
                begin
                    if (cmd.kind == KIND_DISC) begin
                        if (idx == LAST_IDX_DISC) r = SYX_EOX;
                        else                      r = DISC_BODY[body_idx[3:0]];
                    end else begin
                        priority case (1'b1)
                            idx == 5'd14:          r = {1'b0, cmd.channel};
                            idx == 5'd15:          r = 8'h01;
                            idx <= 5'd20:          r = PROF_ID[3'(idx - 5'd16)];
                            idx == 5'd21:          r = 8'h00;
                            default:               r = SYX_EOX;
                        endcase
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mcsr_front.sv -----
// ----------------------------------------------------------------------------
// mcsr_front
// accepts message beats, tracks header fields and classifies the message
// ----------------------------------------------------------------------------
module mcsr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        msg_valid,
    output logic                        msg_stall,
    input  logic [7:0]                  msg_byte,
    input  logic                        msg_end,
    input  logic [mcsr_pkg::ID_W-1:0]   own_id,
    input  logic                        q_full,
    output logic                        q_push,
    output mcsr_pkg::cmd_t              q_wdata
);

    logic [mcsr_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       hdr_good_reg, hdr_good_next;
    logic [6:0]                 channel_reg, channel_next;
    logic [7:0]                 sub_reg, sub_next;
    logic [mcsr_pkg::ID_W-1:0]  sender_reg, sender_next;
    logic [mcsr_pkg::ID_W-1:0]  target_reg, target_next;
    logic                       accept;
    logic                       msg_ok;

    assign msg_stall = q_full;
    assign accept    = msg_valid && !msg_stall;
    assign q_push    = accept && msg_end;

    // field capture for the current beat
    always_comb
    begin
        count_next    = count_reg;
        hdr_good_next = hdr_good_reg;
        channel_next  = channel_reg;
        sub_next      = sub_reg;
        sender_next   = sender_reg;
        target_next   = target_reg;
        if (count_reg < mcsr_pkg::MSG_MIN_LEN) begin
            count_next = count_reg + 5'd1;
            unique case (count_reg[3:0])
                4'd0:  if (msg_byte != mcsr_pkg::SYX_START) hdr_good_next = 1'b0;
                4'd1:  if (msg_byte != mcsr_pkg::SYX_UNIVERSAL) hdr_good_next = 1'b0;
                4'd2:  channel_next = msg_byte[6:0];
                4'd3:  if (msg_byte != mcsr_pkg::SYX_CI) hdr_good_next = 1'b0;
                4'd4:  sub_next = msg_byte;
                4'd6:  sender_next[6:0]   = msg_byte[6:0];
                4'd7:  sender_next[13:7]  = msg_byte[6:0];
                4'd8:  sender_next[20:14] = msg_byte[6:0];
                4'd9:  sender_next[27:21] = msg_byte[6:0];
                4'd10: target_next[6:0]   = msg_byte[6:0];
                4'd11: target_next[13:7]  = msg_byte[6:0];
                4'd12: target_next[20:14] = msg_byte[6:0];
                4'd13: target_next[27:21] = msg_byte[6:0];
                default: ;
            endcase
        end
    end

    assign msg_ok = (count_next >= mcsr_pkg::MSG_MIN_LEN) && hdr_good_next &&
                    ((target_next == mcsr_pkg::BROADCAST_ID) || (target_next == own_id));

    always_comb
    begin
        q_wdata.channel = channel_next;
        q_wdata.sender  = sender_next;
        if (msg_ok && (sub_next == mcsr_pkg::SUB_DISCOVERY))
            q_wdata.kind = mcsr_pkg::KIND_DISC;
        else if (msg_ok && (sub_next == mcsr_pkg::SUB_PROFILE))
            q_wdata.kind = mcsr_pkg::KIND_PROF;
        else
            q_wdata.kind = mcsr_pkg::KIND_REJECT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg    <= '0;
            hdr_good_reg <= 1'b1;
            channel_reg  <= '0;
            sub_reg      <= '0;
            sender_reg   <= '0;
            target_reg   <= '0;
        end else if (accept) begin
            if (msg_end) begin
                count_reg    <= '0;
                hdr_good_reg <= 1'b1;
                channel_reg  <= '0;
                sub_reg      <= '0;
                sender_reg   <= '0;
                target_reg   <= '0;
            end else begin
                count_reg    <= count_next;
                hdr_good_reg <= hdr_good_next;
                channel_reg  <= channel_next;
                sub_reg      <= sub_next;
                sender_reg   <= sender_next;
                target_reg   <= target_next;
            end
        end
    end

endmodule

// ----- rtl/core/mcsr_cmdq.sv -----
// ----------------------------------------------------------------------------
// mcsr_cmdq
// small command fifo between the classifier and the reply generator
// ----------------------------------------------------------------------------
module mcsr_cmdq #(
    parameter int unsigned DEPTH = mcsr_pkg::CMDQ_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mcsr_pkg::cmd_t  wdata,
    input  logic            pop,
    output mcsr_pkg::cmd_t  rdata,
    output logic            full,
    output logic            not_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mcsr_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/core/mcsr_back.sv -----
// ----------------------------------------------------------------------------
// mcsr_back
// walks the head command and streams reply beats through an output register
// ----------------------------------------------------------------------------
module mcsr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mcsr_pkg::cmd_t              q_rdata,
    input  logic                        q_not_empty,
    output logic                        q_pop,
    input  logic [mcsr_pkg::ID_W-1:0]   own_id,
    output logic                        reply_valid,
    input  logic                        reply_stall,
    output logic [7:0]                  reply_byte,
    output logic                        reply_end,
    output logic                        accepted
);

    logic [mcsr_pkg::IDX_W-1:0] idx_reg;
    logic                       out_valid_reg;
    logic [7:0]                 byte_reg;
    logic                       end_reg;
    logic                       acc_reg;
    logic                       load;
    logic                       is_last;

    assign load    = q_not_empty && (!out_valid_reg || !reply_stall);
    assign is_last = (idx_reg == mcsr_pkg::last_idx_f(q_rdata.kind));
    assign q_pop   = load && is_last;

    assign reply_valid = out_valid_reg;
    assign reply_byte  = byte_reg;
    assign reply_end   = end_reg;
    assign accepted    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? '0 : idx_reg + 5'd1;
            end else if (!reply_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg <= mcsr_pkg::reply_byte_f(q_rdata, own_id, idx_reg);
            end_reg  <= is_last;
            acc_reg  <= (q_rdata.kind != mcsr_pkg::KIND_REJECT);
        end
    end

    // a reject is a single zero beat that closes the message
    a_reject_single : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !acc_reg |-> end_reg && (byte_reg == 8'h00))
        else $error("reject beat malformed");

    a_reply_eox : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && acc_reg && end_reg |-> byte_reg == mcsr_pkg::SYX_EOX)
        else $error("reply does not close with eox");

    a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
        q_not_empty |-> idx_reg <= mcsr_pkg::last_idx_f(q_rdata.kind))
        else $error("reply index past end of reply");

    a_idx_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !q_not_empty |-> idx_reg == '0)
        else $error("reply index not cleared between messages");

endmodule

// ----- rtl/core/midi_ci_sysex_responder_core.sv -----
// ----------------------------------------------------------------------------
// midi_ci_sysex_responder_core
// ci discovery / profile inquiry responder for universal sysex messages
//
//   channel  direction  handshake                     payload
//   msg      in         msg_valid / msg_stall         msg_byte, msg_end
//   reply    out        reply_valid / reply_stall     reply_byte, reply_end, accepted
//   apb      in         psel / penable / pready       paddr, pwdata, prdata
//
// one beat accepted per unstalled cycle; classification happens on the end beat
// unstalled replies go one beat per cycle: 31 for discovery, 23 for profile, 1 reject
// up to CMDQ_DEPTH classified messages wait in the command fifo before msg stalls
// reply_stall holds the output register and backs up through the fifo to msg_stall
// reset clears all control state at once, no clearing pass
// ----------------------------------------------------------------------------
module midi_ci_sysex_responder_core #(
    parameter int unsigned CMDQ_DEPTH = mcsr_pkg::CMDQ_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  msg_byte,
    input  logic        msg_end,
    output logic        reply_valid,
    input  logic        reply_stall,
    output logic [7:0]  reply_byte,
    output logic        reply_end,
    output logic        accepted
);

    logic [mcsr_pkg::ID_W-1:0] own_id_reg;
    logic                      q_push, q_pop, q_full, q_not_empty;
    mcsr_pkg::cmd_t            q_wdata, q_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == mcsr_pkg::ADDR_OWN_ID) ? {4'b0, own_id_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_id_reg <= '0;
        else if (psel && penable && pwrite && pready && (paddr == mcsr_pkg::ADDR_OWN_ID))
            own_id_reg <= pwdata[mcsr_pkg::ID_W-1:0];
    end

    mcsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_byte  (msg_byte),
        .msg_end   (msg_end),
        .own_id    (own_id_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    mcsr_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    mcsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rdata     (q_rdata),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .own_id      (own_id_reg),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply_byte  (reply_byte),
        .reply_end   (reply_end),
        .accepted    (accepted)
    );

endmodule
